// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the execute unit files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RVEX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define RVEX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/rvex_pkg.sv =====
// types and constants of the rv32im execute unit
package rvex_pkg;

  typedef struct packed {
    logic               command;
    logic [6:0]         opcode;
    logic [2:0]         funct3;
    logic [6:0]         funct7;
    logic [4:0]         dest_index;
    logic [4:0]         src1_index;
    logic [4:0]         src2_index;
    logic signed [31:0] immediate;
    logic [31:0]        load_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] mem_address;
    logic [1:0]  mem_size;
    logic [31:0] store_data;
    logic        write_enable;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic [31:0] next_pc;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic [2:0] funct3;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } md_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_MD, S_DONE
  } ex_state_t;

  typedef enum logic [1:0] {
    MD_IDLE, MD_RUN, MD_FIX
  } md_state_t;

  localparam logic [2:0] KIND_RETIRED = 3'd0;
  localparam logic [2:0] KIND_READ    = 3'd1;
  localparam logic [2:0] KIND_WRITE   = 3'd2;
  localparam logic [2:0] KIND_TRAP    = 3'd3;
  localparam logic [2:0] KIND_ILLEGAL = 3'd4;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_UPC    = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRC    = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STR    = 7'h23;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_MEMORD = 7'h0F;
  localparam logic [6:0] OPC_PRIV   = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MD   = 7'h01;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  localparam logic [2:0] F3_PRIV = 3'd0;

endpackage

// ===== rtl/core/rvex_chan_if.sv =====
// valid/ready channel carrying one payload
interface rvex_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rvex_ram.sv =====
// generic single-write single-read ram with registered read
module rvex_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/core/rvex_muldiv.sv =====
// bit-serial multiply and divide unit, one bit per cycle
`include "assert_macros.svh"
module rvex_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  rvex_pkg::md_req_t req,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output rvex_pkg::md_rsp_t rsp
);
  import rvex_pkg::*;

  md_state_t   state_r, state_nxt;
  logic [2:0]  f3_r;
  logic [4:0]  cnt_r;
  logic [31:0] hi_r, lo_r, d_r, orig_r, res_r;
  logic        neg_r, bz_r, done_r;

  logic        sa, sb;
  logic [31:0] ua, ub;
  logic [32:0] msum, rsh, diff;
  logic [63:0] prod, pneg;
  logic [31:0] fix_res;

  always_comb begin
    sa = ((req.funct3 == F3_MULH) || (req.funct3 == F3_MULHSU) ||
          (req.funct3 == F3_DIV) || (req.funct3 == F3_REM)) && a[31];
    sb = ((req.funct3 == F3_MULH) || (req.funct3 == F3_DIV) ||
          (req.funct3 == F3_REM)) && b[31];
    ua = sa ? (32'd0 - a) : a;
    ub = sb ? (32'd0 - b) : b;
    msum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, d_r} : 33'd0);
    rsh  = {hi_r, lo_r[31]};
    diff = rsh - {1'b0, d_r};
    prod = {hi_r, lo_r};
    pneg = neg_r ? (64'd0 - prod) : prod;
    case (f3_r)
      F3_MUL:                     fix_res = pneg[31:0];
      F3_MULH, F3_MULHSU,
      F3_MULHU:                   fix_res = pneg[63:32];
      F3_DIV, F3_DIVU:            fix_res = bz_r ? 32'hFFFF_FFFF :
                                            (neg_r ? (32'd0 - lo_r) : lo_r);
      default:                    fix_res = bz_r ? orig_r :
                                            (neg_r ? (32'd0 - hi_r) : hi_r);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MD_IDLE: if (req.start) state_nxt = MD_RUN;
      MD_RUN:  if (cnt_r == 5'd31) state_nxt = MD_FIX;
      MD_FIX:  state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == MD_FIX);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          f3_r   <= req.funct3;
          hi_r   <= '0;
          lo_r   <= ua;
          d_r    <= ub;
          orig_r <= a;
          bz_r   <= (b == 32'd0);
          neg_r  <= (req.funct3 == F3_REM) ? sa : (sa ^ sb);
          cnt_r  <= '0;
        end
      end
      MD_RUN: begin
        cnt_r <= cnt_r + 5'd1;
        if (f3_r[2]) begin
          if (!diff[32]) begin
            hi_r <= diff[31:0];
            lo_r <= {lo_r[30:0], 1'b1};
          end else begin
            hi_r <= rsh[31:0];
            lo_r <= {lo_r[30:0], 1'b0};
          end
        end else begin
          hi_r <= msum[32:1];
          lo_r <= {msum[0], lo_r[31:1]};
        end
      end
      MD_FIX: res_r <= fix_res;
      default: ;
    endcase
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

  `RVEX_ASSERT_NXT(a_md_start, clk, rst_n, (state_r == MD_IDLE) && req.start, state_r == MD_RUN)
  `RVEX_ASSERT_NXT(a_md_pulse, clk, rst_n, done_r, !done_r && (state_r == MD_IDLE))
endmodule

// ===== rtl/core/rv32im_execute_unit.sv =====
// rv32im execute unit top level
//   channel  dir  payload     transfer
//   in_if    in   in_item_t   valid & ready
//   out_if   out  out_item_t  valid & ready
//   cfg_if   in   pc value    valid & ready, always ready
// an item steps through two register file reads, execute and commit before the next accept
// multiply and divide wait in S_MD for the serial unit (32 one-bit steps)
// reset clears the valid bits of the register file, the pc and pending load
// a new item is taken while a finished result waits on out_if; commit stalls
// until the output register is free
`include "assert_macros.svh"
module rv32im_execute_unit #(
  parameter int REGISTER_COUNT = 32
) (
  input logic        clk,
  input logic        rst_n,
  rvex_chan_if.sink   in_if,
  rvex_chan_if.source out_if,
  rvex_chan_if.sink   cfg_if
);
  import rvex_pkg::*;

  localparam int         AW = $clog2(REGISTER_COUNT);
  localparam logic [5:0] RC = 6'(REGISTER_COUNT);

  ex_state_t state_r, state_nxt;
  in_item_t  cmd_r;
  out_item_t res_r, res_c, out_data_r;
  logic      out_valid_r;
  logic [31:0] pc_r, a_r, b_r;
  logic        pend_r;
  logic [4:0]  pend_dest_r;
  logic [2:0]  pend_type_r;
  logic        set_pend_r, clr_pend_r, set_pend_c, clr_pend_c, md_go_c;
  logic [REGISTER_COUNT-1:0] vld_r;

  logic          accept, commit;
  logic [4:0]    rsel;
  logic [AW-1:0] raddr;
  logic          rok_c, rok_r;
  logic [31:0]   rdata, rval;
  md_req_t       md_req;
  md_rsp_t       md_rsp;

  logic [31:0] imm, nxt, wv, ld_ext, alu_b, alu_res, tgt;
  logic [4:0]  wdst;
  logic        ok, wr, taken, alu_alt, lt_s, lt_u;

  assign accept = in_if.valid && in_if.ready;
  assign commit = (state_r == S_DONE) && (!out_valid_r || out_if.ready);
  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  // register file read port
  always_comb begin
    rsel  = (state_r == S_IDLE) ? in_if.data.src1_index : cmd_r.src2_index;
    raddr = rsel[AW-1:0];
    rok_c = (rsel != 5'd0) && ({1'b0, rsel} < RC) && vld_r[raddr];
  end
  assign rval = rok_r ? rdata : 32'd0;

  rvex_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_rf (
    .clk   (clk),
    .we    (commit && res_r.write_enable),
    .waddr (res_r.write_index[AW-1:0]),
    .wdata (res_r.write_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign md_req.start  = (state_r == S_EXEC) && md_go_c;
  assign md_req.funct3 = cmd_r.funct3;

  rvex_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .a     (a_r),
    .b     (b_r),
    .rsp   (md_rsp)
  );

  // alu and branch compare
  always_comb begin
    imm   = cmd_r.immediate;
    alu_b = (cmd_r.opcode == OPC_IMM) ? imm : b_r;
    alu_alt = (cmd_r.funct7 == F7_ALT);
    lt_s  = $signed(a_r) < $signed(alu_b);
    lt_u  = a_r < alu_b;
    case (cmd_r.funct3)
      F3_ADD:  alu_res = (alu_alt && (cmd_r.opcode == OPC_REG)) ? (a_r - alu_b)
                                                                : (a_r + alu_b);
      F3_SLL:  alu_res = a_r << alu_b[4:0];
      F3_SLT:  alu_res = {31'd0, lt_s};
      F3_SLTU: alu_res = {31'd0, lt_u};
      F3_XOR:  alu_res = a_r ^ alu_b;
      F3_SR:   alu_res = alu_alt ? 32'($signed(a_r) >>> alu_b[4:0])
                                 : (a_r >> alu_b[4:0]);
      F3_OR:   alu_res = a_r | alu_b;
      default: alu_res = a_r & alu_b;
    endcase
    case (pend_type_r)
      F3_LB:   ld_ext = {{24{cmd_r.load_data[7]}}, cmd_r.load_data[7:0]};
      F3_LH:   ld_ext = {{16{cmd_r.load_data[15]}}, cmd_r.load_data[15:0]};
      F3_LBU:  ld_ext = {24'd0, cmd_r.load_data[7:0]};
      F3_LHU:  ld_ext = {16'd0, cmd_r.load_data[15:0]};
      default: ld_ext = cmd_r.load_data;
    endcase
    tgt = a_r + imm;
  end

  // execute step
  always_comb begin
    res_c = '0;
    ok = 1'b1;
    wr = 1'b0;
    wv = '0;
    wdst = cmd_r.dest_index;
    nxt = pc_r + 32'd4;
    taken = 1'b0;
    set_pend_c = 1'b0;
    clr_pend_c = 1'b0;
    md_go_c = 1'b0;
    if (cmd_r.command) begin
      nxt = pc_r;
      if (pend_r) begin
        wr = 1'b1;
        wdst = pend_dest_r;
        wv = ld_ext;
        clr_pend_c = 1'b1;
      end
    end else begin
      case (cmd_r.opcode)
        OPC_LUI: begin
          wr = 1'b1;
          wv = imm;
        end
        OPC_UPC: begin
          wr = 1'b1;
          wv = pc_r + imm;
        end
        OPC_JAL: begin
          wr = 1'b1;
          wv = pc_r + 32'd4;
          nxt = pc_r + imm;
        end
        OPC_JALR: begin
          if (cmd_r.funct3 != F3_ADD) begin
            ok = 1'b0;
          end else begin
            wr = 1'b1;
            wv = pc_r + 32'd4;
            nxt = {tgt[31:1], 1'b0};
          end
        end
        OPC_BRC: begin
          case (cmd_r.funct3)
            F3_BEQ:  taken = (a_r == b_r);
            F3_BNE:  taken = (a_r != b_r);
            F3_BLT:  taken = lt_s;
            F3_BGE:  taken = !lt_s;
            F3_BLTU: taken = lt_u;
            F3_BGEU: taken = !lt_u;
            default: ok = 1'b0;
          endcase
          if (taken) nxt = pc_r + imm;
        end
        OPC_LOAD: begin
          if (!(cmd_r.funct3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU})) begin
            ok = 1'b0;
          end else begin
            res_c.result_kind = KIND_READ;
            res_c.mem_address = tgt;
            res_c.mem_size = cmd_r.funct3[1:0];
            set_pend_c = 1'b1;
          end
        end
        OPC_STR: begin
          if (!(cmd_r.funct3 inside {F3_LB, F3_LH, F3_LW})) begin
            ok = 1'b0;
          end else begin
            res_c.result_kind = KIND_WRITE;
            res_c.mem_address = tgt;
            res_c.mem_size = cmd_r.funct3[1:0];
            case (cmd_r.funct3)
              F3_LB:   res_c.store_data = {24'd0, b_r[7:0]};
              F3_LH:   res_c.store_data = {16'd0, b_r[15:0]};
              default: res_c.store_data = b_r;
            endcase
          end
        end
        OPC_IMM: begin
          if ((cmd_r.funct3 == F3_SLL) && (cmd_r.funct7 != F7_BASE)) begin
            ok = 1'b0;
          end else if ((cmd_r.funct3 == F3_SR) && (cmd_r.funct7 != F7_BASE) &&
                       !alu_alt) begin
            ok = 1'b0;
          end else begin
            wr = 1'b1;
            wv = alu_res;
          end
        end
        OPC_REG: begin
          if (cmd_r.funct7 == F7_MD) begin
            wr = 1'b1;
            md_go_c = 1'b1;
          end else if (cmd_r.funct7 == F7_BASE) begin
            wr = 1'b1;
            wv = alu_res;
          end else if (alu_alt && (cmd_r.funct3 inside {F3_ADD, F3_SR})) begin
            wr = 1'b1;
            wv = alu_res;
          end else begin
            ok = 1'b0;
          end
        end
        OPC_MEMORD: ;
        OPC_PRIV: begin
          if ((cmd_r.funct3 == F3_PRIV) && (imm[11:0] <= 12'd1)) begin
            res_c.result_kind = KIND_TRAP;
            res_c.mem_address = pc_r;
            res_c.mem_size = {1'b0, imm[0]};
          end else begin
            ok = 1'b0;
          end
        end
        default: ok = 1'b0;
      endcase
    end
    if (wr && (wdst != 5'd0) && ({1'b0, wdst} < RC)) begin
      res_c.write_enable = 1'b1;
      res_c.write_index = wdst;
      res_c.write_value = wv;
    end
    res_c.next_pc = nxt;
    if (!ok) begin
      res_c = '0;
      res_c.result_kind = KIND_ILLEGAL;
      res_c.next_pc = pc_r;
      set_pend_c = 1'b0;
      md_go_c = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_EXEC;
      S_EXEC:  state_nxt = md_go_c ? S_MD : S_DONE;
      S_MD:    if (md_rsp.done) state_nxt = S_DONE;
      S_DONE:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      pend_r      <= 1'b0;
      pend_dest_r <= '0;
      pend_type_r <= '0;
      vld_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
        pc_r <= res_r.next_pc;
        if (res_r.write_enable) vld_r[res_r.write_index[AW-1:0]] <= 1'b1;
        if (set_pend_r) begin
          pend_r      <= 1'b1;
          pend_dest_r <= cmd_r.dest_index;
          pend_type_r <= cmd_r.funct3;
        end else if (clr_pend_r) begin
          pend_r <= 1'b0;
        end
      end else begin
        if (out_if.ready) out_valid_r <= 1'b0;
        if (cfg_if.valid) pc_r <= cfg_if.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rok_r <= rok_c;
    if (accept) cmd_r <= in_if.data;
    if (state_r == S_RD1) a_r <= rval;
    if (state_r == S_RD2) b_r <= rval;
    if (state_r == S_EXEC) begin
      res_r      <= res_c;
      set_pend_r <= set_pend_c;
      clr_pend_r <= clr_pend_c;
    end
    if ((state_r == S_MD) && md_rsp.done) begin
      res_r.write_value <= res_r.write_enable ? md_rsp.result : 32'd0;
    end
    if (commit) out_data_r <= res_r;
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  `RVEX_ASSERT_NXT(a_accept_read, clk, rst_n, accept, state_r == S_RD1)
  `RVEX_ASSERT_IMP(a_no_x0_write, clk, rst_n, commit && res_r.write_enable, res_r.write_index != 5'd0)
  `RVEX_ASSERT_IMP(a_illegal_clean, clk, rst_n, out_valid_r && (out_data_r.result_kind == KIND_ILLEGAL), !out_data_r.write_enable && (out_data_r.mem_address == 32'd0))
endmodule

// ===== verif/rv32im_execute_unit_test.sv =====
// self-checking testbench for the rv32im execute unit
`timescale 1ns / 100ps
module rv32im_execute_unit_test;
  import rvex_pkg::*;

  logic clk;
  logic rst_n;
  int unsigned cycle_count;
  int unsigned fail_count;

  rvex_chan_if #(.payload_t(in_item_t))    in_if ();
  rvex_chan_if #(.payload_t(out_item_t))   out_if ();
  rvex_chan_if #(.payload_t(logic [31:0])) cfg_if ();

  rv32im_execute_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // predictor state
  logic [31:0] gold_regs [32];
  logic [31:0] gold_pc;
  logic        gold_load_busy;
  logic [4:0]  gold_load_dest;
  logic [2:0]  gold_load_type;
  out_item_t   expected_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_recv;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 1500000) begin
        $display("** rv32im_execute_unit: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [31:0] reg_read(input logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : gold_regs[idx];
  endfunction

  function automatic void reg_write(input logic [4:0] idx, input logic [31:0] val,
                                    inout out_item_t r);
    if (idx != 5'd0) begin
      gold_regs[idx] = val;
      r.write_enable = 1'b1;
      r.write_index = idx;
      r.write_value = val;
    end
  endfunction

  function automatic logic [31:0] muldiv_calc(input logic [2:0] f3, input logic [31:0] a,
                                              input logic [31:0] b);
    logic signed [63:0] ps;
    logic [63:0] pu;
    logic signed [64:0] psu;
    case (f3)
      F3_MUL: return a * b;
      F3_MULH: begin
        ps = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        return ps[63:32];
      end
      F3_MULHSU: begin
        psu = $signed({{33{a[31]}}, a}) * $signed({33'd0, b});
        return psu[63:32];
      end
      F3_MULHU: begin
        pu = {32'd0, a} * {32'd0, b};
        return pu[63:32];
      end
      F3_DIV: begin
        if (b == 0) return 32'hFFFF_FFFF;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'h8000_0000;
        return $signed(a) / $signed(b);
      end
      F3_DIVU: return (b == 0) ? 32'hFFFF_FFFF : a / b;
      F3_REM: begin
        if (b == 0) return a;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'd0;
        return $signed(a) % $signed(b);
      end
      default: return (b == 0) ? a : a % b;
    endcase
  endfunction

  function automatic out_item_t execute_item(input in_item_t t);
    out_item_t r;
    logic [31:0] a, b, imm, nxt, v;
    logic ok;
    logic tk;
    r = '0;
    a = reg_read(t.src1_index);
    b = reg_read(t.src2_index);
    imm = t.immediate;
    nxt = gold_pc + 32'd4;
    ok = 1'b1;
    r.result_kind = KIND_RETIRED;
    if (t.command) begin
      if (gold_load_busy) begin
        case (gold_load_type)
          F3_LB:  v = {{24{t.load_data[7]}}, t.load_data[7:0]};
          F3_LH:  v = {{16{t.load_data[15]}}, t.load_data[15:0]};
          F3_LBU: v = {24'd0, t.load_data[7:0]};
          F3_LHU: v = {16'd0, t.load_data[15:0]};
          default: v = t.load_data;
        endcase
        reg_write(gold_load_dest, v, r);
        gold_load_busy = 1'b0;
      end
      r.next_pc = gold_pc;
      return r;
    end
    case (t.opcode)
      OPC_LUI:   reg_write(t.dest_index, imm, r);
      OPC_UPC: reg_write(t.dest_index, gold_pc + imm, r);
      OPC_JAL: begin
        reg_write(t.dest_index, gold_pc + 32'd4, r);
        nxt = gold_pc + imm;
      end
      OPC_JALR: begin
        if (t.funct3 != 3'd0) ok = 1'b0;
        else begin
          nxt = (a + imm) & ~32'd1;
          reg_write(t.dest_index, gold_pc + 32'd4, r);
        end
      end
      OPC_BRC: begin
        tk = 1'b0;
        case (t.funct3)
          F3_BEQ:  tk = (a == b);
          F3_BNE:  tk = (a != b);
          F3_BLT:  tk = ($signed(a) < $signed(b));
          F3_BGE:  tk = ($signed(a) >= $signed(b));
          F3_BLTU: tk = (a < b);
          F3_BGEU: tk = (a >= b);
          default: ok = 1'b0;
        endcase
        if (tk) nxt = gold_pc + imm;
      end
      OPC_LOAD: begin
        if (t.funct3 == 3'd3 || t.funct3 > 3'd5) ok = 1'b0;
        else begin
          r.result_kind = KIND_READ;
          r.mem_address = a + imm;
          r.mem_size = t.funct3[1:0];
          gold_load_busy = 1'b1;
          gold_load_dest = t.dest_index;
          gold_load_type = t.funct3;
        end
      end
      OPC_STR: begin
        if (t.funct3 > 3'd2) ok = 1'b0;
        else begin
          r.result_kind = KIND_WRITE;
          r.mem_address = a + imm;
          r.mem_size = t.funct3[1:0];
          r.store_data = (t.funct3 == 3'd0) ? (b & 32'hFF) :
                         (t.funct3 == 3'd1) ? (b & 32'hFFFF) : b;
        end
      end
      OPC_IMM: begin
        case (t.funct3)
          F3_ADD:  v = a + imm;
          F3_SLL:  begin
            v = a << imm[4:0];
            if (t.funct7 != F7_BASE) ok = 1'b0;
          end
          F3_SLT:  v = {31'd0, $signed(a) < $signed(imm)};
          F3_SLTU: v = {31'd0, a < imm};
          F3_XOR:  v = a ^ imm;
          F3_SR: begin
            if (t.funct7 == F7_BASE) v = a >> imm[4:0];
            else if (t.funct7 == F7_ALT) v = $signed(a) >>> imm[4:0];
            else ok = 1'b0;
          end
          F3_OR:   v = a | imm;
          default: v = a & imm;
        endcase
        if (ok) reg_write(t.dest_index, v, r);
      end
      OPC_REG: begin
        v = '0;
        if (t.funct7 == F7_MD) v = muldiv_calc(t.funct3, a, b);
        else if (t.funct7 == F7_ALT) begin
          if (t.funct3 == F3_ADD) v = a - b;
          else if (t.funct3 == F3_SR) v = $signed(a) >>> b[4:0];
          else ok = 1'b0;
        end else if (t.funct7 != F7_BASE) ok = 1'b0;
        else begin
          case (t.funct3)
            F3_ADD:  v = a + b;
            F3_SLL:  v = a << b[4:0];
            F3_SLT:  v = {31'd0, $signed(a) < $signed(b)};
            F3_SLTU: v = {31'd0, a < b};
            F3_XOR:  v = a ^ b;
            F3_SR:   v = a >> b[4:0];
            F3_OR:   v = a | b;
            default: v = a & b;
          endcase
        end
        if (ok) reg_write(t.dest_index, v, r);
      end
      OPC_MEMORD: ;
      OPC_PRIV: begin
        if (t.funct3 == F3_PRIV && imm[11:0] <= 12'd1) begin
          r.result_kind = KIND_TRAP;
          r.mem_address = gold_pc;
          r.mem_size = {1'b0, imm[0]};
        end else ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      // illegal encodings leave all state untouched
      r = '0;
      r.result_kind = KIND_ILLEGAL;
      nxt = gold_pc;
    end
    gold_pc = nxt;
    r.next_pc = nxt;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    out_item_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected transaction: actual %h", $time, got);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.result_kind !== exp_r.result_kind)
          $display("%0t result_kind exp %0d act %0d", $time, exp_r.result_kind,
                   got.result_kind);
        if (got.mem_address !== exp_r.mem_address)
          $display("%0t mem_address exp %h act %h", $time, exp_r.mem_address,
                   got.mem_address);
        if (got.mem_size !== exp_r.mem_size)
          $display("%0t mem_size exp %0d act %0d", $time, exp_r.mem_size, got.mem_size);
        if (got.store_data !== exp_r.store_data)
          $display("%0t store_data exp %h act %h", $time, exp_r.store_data,
                   got.store_data);
        if (got.write_enable !== exp_r.write_enable)
          $display("%0t write_enable exp %0d act %0d", $time, exp_r.write_enable,
                   got.write_enable);
        if (got.write_index !== exp_r.write_index)
          $display("%0t write_index exp %0d act %0d", $time, exp_r.write_index,
                   got.write_index);
        if (got.write_value !== exp_r.write_value)
          $display("%0t write_value exp %h act %h", $time, exp_r.write_value,
                   got.write_value);
        if (got.next_pc !== exp_r.next_pc)
          $display("%0t next_pc exp %h act %h", $time, exp_r.next_pc, got.next_pc);
        if (got !== exp_r) fail_count++;
      end
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else if (hold_recv) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays high after a transaction when the next item follows at once
  task automatic send_item(input in_item_t t, input bit use_gold, input out_item_t gold);
    out_item_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= t;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    p = execute_item(t);
    if (use_gold && p !== gold) begin
      $display("%0t predictor disagrees with table: expected %h actual %h", $time,
               gold, p);
      fail_count++;
    end
    expected_results.push_back(p);
  endtask

  task automatic drain();
    int unsigned lim;
    lim = cycle_count + 200000;
    while (expected_results.size() != 0 && cycle_count < lim) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_start(input logic [31:0] addr);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= addr;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    gold_pc = addr;
    @(posedge clk);
  endtask

  function automatic in_item_t make_instr(input logic [6:0] op, input logic [2:0] f3,
                                          input logic [6:0] f7, input logic [4:0] rd,
                                          input logic [4:0] rs1, input logic [4:0] rs2,
                                          input logic [31:0] imm);
    in_item_t t;
    t.command = 1'b0;
    t.opcode = op;
    t.funct3 = f3;
    t.funct7 = f7;
    t.dest_index = rd;
    t.src1_index = rs1;
    t.src2_index = rs2;
    t.immediate = imm;
    t.load_data = $urandom;
    return t;
  endfunction

  function automatic in_item_t make_return(input logic [31:0] data);
    in_item_t t;
    t = make_instr(7'd0, 3'd0, 7'd0, 5'($urandom), 5'($urandom), 5'($urandom), $urandom);
    t.command = 1'b1;
    t.load_data = data;
    return t;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      3: return $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    logic [6:0] ops [11];
    logic [6:0] f7;
    logic [31:0] imm;
    ops = '{OPC_LUI, OPC_UPC, OPC_JAL, OPC_JALR, OPC_BRC, OPC_LOAD, OPC_STR,
            OPC_IMM, OPC_REG, OPC_MEMORD, OPC_PRIV};
    case ($urandom_range(9))
      0: f7 = F7_ALT;
      1, 2: f7 = F7_MD;
      3: f7 = 7'($urandom);
      default: f7 = F7_BASE;
    endcase
    imm = ($urandom_range(3) == 0) ? rand_operand() : 32'($signed(12'($urandom)));
    if ($urandom_range(15) == 0) return make_return(rand_operand());
    if ($urandom_range(19) == 0)
      return make_instr(7'($urandom), 3'($urandom), 7'($urandom), 5'($urandom),
                        5'($urandom), 5'($urandom), $urandom);
    if ($urandom_range(9) == 0) begin
      // load, which run_random often follows with its return
      return make_instr(OPC_LOAD, 3'($urandom), f7, 5'($urandom), 5'($urandom),
                        5'($urandom), imm);
    end
    if ($urandom_range(11) == 0)
      return make_instr(OPC_PRIV, ($urandom_range(3) == 0) ? 3'($urandom) : F3_PRIV, f7,
                        5'($urandom), 5'($urandom), 5'($urandom),
                        ($urandom_range(2) == 0) ? $urandom : $urandom_range(1));
    return make_instr(ops[4'($urandom_range(10))], 3'($urandom), f7, 5'($urandom),
                      5'($urandom), 5'($urandom), imm);
  endfunction

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t gold;
  } table_row_t;

  table_row_t directed_rows [$];

  function automatic out_item_t retired_write(input logic [4:0] idx, input logic [31:0] v,
                                              input logic [31:0] pc);
    out_item_t r;
    r = '0;
    r.result_kind = KIND_RETIRED;
    r.write_enable = 1'b1;
    r.write_index = idx;
    r.write_value = v;
    r.next_pc = pc;
    return r;
  endfunction

  function automatic out_item_t plain_result(input logic [2:0] kind, input logic [31:0] pc);
    out_item_t r;
    r = '0;
    r.result_kind = kind;
    r.next_pc = pc;
    return r;
  endfunction

  function automatic void add_row(input in_item_t t, input bit typed, input out_item_t g);
    table_row_t row;
    row.stim = t;
    row.typed = typed;
    row.gold = g;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_table();
    out_item_t g;
    // pc starts at 0 after reset
    add_row(make_return(32'h1234_5678), 1'b1, plain_result(KIND_RETIRED, 32'd0));
    add_row(make_instr(OPC_LUI, 3'd0, F7_BASE, 5'd1, 5'd0, 5'd0, 32'h8000_0000), 1'b1,
            retired_write(5'd1, 32'h8000_0000, 32'd4));
    add_row(make_instr(OPC_IMM, F3_ADD, F7_BASE, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF), 1'b1,
            retired_write(5'd2, 32'hFFFF_FFFF, 32'd8));
    add_row(make_instr(OPC_LUI, 3'd0, F7_BASE, 5'd0, 5'd0, 5'd0, 32'h7FFF_F000), 1'b1,
            plain_result(KIND_RETIRED, 32'd12));
    add_row(make_instr(OPC_REG, F3_DIV, F7_MD, 5'd3, 5'd1, 5'd2, 32'd0), 1'b1,
            retired_write(5'd3, 32'h8000_0000, 32'd16));
    add_row(make_instr(OPC_REG, F3_REM, F7_MD, 5'd4, 5'd1, 5'd2, 32'd0), 1'b1,
            retired_write(5'd4, 32'd0, 32'd20));
    add_row(make_instr(OPC_REG, F3_DIVU, F7_MD, 5'd5, 5'd1, 5'd0, 32'd0), 1'b1,
            retired_write(5'd5, 32'hFFFF_FFFF, 32'd24));
    add_row(make_instr(OPC_REG, F3_REMU, F7_MD, 5'd6, 5'd1, 5'd0, 32'd0), 1'b1,
            retired_write(5'd6, 32'h8000_0000, 32'd28));
    add_row(make_instr(7'h7F, 3'd0, F7_BASE, 5'd7, 5'd1, 5'd1, 32'd0), 1'b1,
            plain_result(KIND_ILLEGAL, 32'd28));
    g = plain_result(KIND_TRAP, 32'd32);
    g.mem_address = 32'd28;
    add_row(make_instr(OPC_PRIV, F3_PRIV, F7_BASE, 5'd0, 5'd0, 5'd0, 32'd0), 1'b1, g);
    g = plain_result(KIND_TRAP, 32'd36);
    g.mem_address = 32'd32;
    g.mem_size = 2'd1;
    add_row(make_instr(OPC_PRIV, F3_PRIV, F7_BASE, 5'd0, 5'd0, 5'd0, 32'd1), 1'b1, g);
    add_row(make_instr(OPC_PRIV, F3_PRIV, F7_BASE, 5'd0, 5'd0, 5'd0, 32'h2), 1'b1,
            plain_result(KIND_ILLEGAL, 32'd36));
    add_row(make_instr(OPC_MEMORD, 3'd0, F7_BASE, 5'd9, 5'd1, 5'd2, 32'd0), 1'b1,
            plain_result(KIND_RETIRED, 32'd40));
    add_row(make_instr(OPC_REG, F3_SLL, F7_ALT, 5'd8, 5'd1, 5'd2, 32'd0), 1'b1,
            plain_result(KIND_ILLEGAL, 32'd40));
    // remaining rows from the predictor
    add_row(make_instr(OPC_REG, F3_MULH, F7_MD, 5'd9, 5'd1, 5'd2, 32'd0), 1'b0, '0);
    add_row(make_instr(OPC_REG, F3_MULHSU, F7_MD, 5'd10, 5'd1, 5'd2, 32'd0), 1'b0, '0);
    add_row(make_instr(OPC_REG, F3_MULHU, F7_MD, 5'd11, 5'd2, 5'd2, 32'd0), 1'b0, '0);
    add_row(make_instr(OPC_IMM, F3_SR, F7_ALT, 5'd12, 5'd1, 5'd0, 32'd31), 1'b0, '0);
    add_row(make_instr(OPC_STR, 3'd1, F7_BASE, 5'd0, 5'd2, 5'd1, 32'h7FF), 1'b0, '0);
    add_row(make_instr(OPC_LOAD, F3_LB, F7_BASE, 5'd13, 5'd1, 5'd0, 32'hFFFF_F800), 1'b0,
            '0);
    add_row(make_instr(OPC_LOAD, F3_LHU, F7_BASE, 5'd14, 5'd2, 5'd0, 32'd4), 1'b0, '0);
    add_row(make_return(32'hFFFF_8080), 1'b0, '0);
    add_row(make_instr(OPC_BRC, F3_BLT, F7_BASE, 5'd0, 5'd1, 5'd2, 32'h100), 1'b0, '0);
    add_row(make_instr(OPC_JALR, 3'd0, F7_BASE, 5'd15, 5'd2, 5'd0, 32'd0), 1'b0, '0);
    add_row(make_instr(OPC_JAL, 3'd0, F7_BASE, 5'd31, 5'd0, 5'd0, 32'h8000_0000), 1'b0, '0);
  endfunction

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    in_item_t t;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      t = rand_item();
      send_item(t, 1'b0, '0);
      if (t.command == 1'b0 && t.opcode == OPC_LOAD && $urandom_range(3) != 0)
        send_item(make_return(rand_operand()), 1'b0, '0);
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    hold_recv = 1'b0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    gold_pc = '0;
    gold_load_busy = 1'b0;
    gold_load_dest = '0;
    gold_load_type = '0;
    foreach (gold_regs[i]) gold_regs[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_table();
    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].gold);
    in_if.valid <= 1'b0;
    drain();

    write_start(32'hFFFF_FFFC);
    run_random(260, 0, 0);
    drain();
    write_start(32'h0000_1000);
    run_random(260, 46, 0);
    drain();
    write_start(32'd0);
    run_random(260, 0, 46);
    drain();
    write_start($urandom);
    fork
      run_random(260, 35, 35);
      begin
        // long receiver hold so the block backs up
        repeat (50) @(posedge clk);
        hold_recv = 1'b1;
        repeat (400) @(posedge clk);
        hold_recv = 1'b0;
      end
    join
    drain();
    write_start(32'hFFFF_FFFF);
    run_random(240, 0, 0);
    drain();

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("** rv32im_execute_unit: PASSED **");
    end else begin
      $display("** rv32im_execute_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== rv32im_execute_unit.f =====
+incdir+rtl/core
rtl/core/rvex_pkg.sv
rtl/core/rvex_chan_if.sv
rtl/core/rvex_ram.sv
rtl/core/rvex_muldiv.sv
rtl/core/rv32im_execute_unit.sv
verif/rv32im_execute_unit_test.sv
